>>> rtl/core/dh_chain_forward_kinematics_defines.svh
// ----------------------------------------------------------------------------
// DH chain forward kinematics: assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DH_CHAIN_FORWARD_KINEMATICS_DEFINES_SVH
`define DH_CHAIN_FORWARD_KINEMATICS_DEFINES_SVH

// Check a property on every clock edge outside reset
`define DHFK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define DHFK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// DH chain forward kinematics: package
// Fixed-point types, polynomial constants and frame arithmetic helpers.
// ----------------------------------------------------------------------------
package dhfk_pkg;

   // Sine and cosine values, Q1.15
   typedef logic signed [16:0] trig_type;
   // Rotation entries, Q1.15 held wide
   typedef logic signed [19:0] rot_type;
   // Translation entries, Q.14 held wide
   typedef logic signed [27:0] pos_type;
   // Single products and sums of three products
   typedef logic signed [47:0] prod_type;
   typedef logic signed [49:0] sum_type;
   // Saturated output coordinate
   typedef logic signed [18:0] coord_type;

   // Sine and cosine of all four joints
   typedef struct {
      trig_type cs [4];
      trig_type sn [4];
   } trig_item_type;

   // Homogeneous frame: rotation and translation
   typedef struct {
      rot_type r [3][3];
      pos_type p [3];
   } frame_type;

   // Registered partial products of one frame composition
   typedef struct {
      prod_type rr [3][3][3];
      prod_type rp [3][3];
      pos_type  ap [3];
   } cprod_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_FEMUR_LENGTH = 2'd0,
      CSR_TIBIA_LENGTH = 2'd1,
      CSR_FOOT_LENGTH  = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   localparam int       QUEUE_DEPTH = 4;
   localparam trig_type TRIG_ONE    = 17'sd32768;
   localparam rot_type  ROT_ONE     = 20'sd32768;
   localparam coord_type COORD_MAX  = 19'sd262143;
   localparam coord_type COORD_MIN  = -19'sd262144;

   // Odd sine polynomial coefficients, Q2.30, lowest order first
   localparam logic signed [32:0] SIN_POLY [5] = '{
      33'sd1686629713, -33'sd693598668, 33'sd85569306, -33'sd5026995, 33'sd172272
   };

   // Round half up by 15 bits
   function automatic sum_type round15(sum_type v);
      return (v + 50'sd16384) >>> 15;
   endfunction

   // First joint: alpha of a quarter turn, no link offset
   function automatic frame_type base_frame(trig_type c, trig_type s);
      frame_type f;
      f.r[0][0] = rot_type'(c);
      f.r[0][1] = '0;
      f.r[0][2] = rot_type'(s);
      f.r[1][0] = rot_type'(s);
      f.r[1][1] = '0;
      f.r[1][2] = -rot_type'(c);
      f.r[2][0] = '0;
      f.r[2][1] = ROT_ONE;
      f.r[2][2] = '0;
      f.p[0]    = '0;
      f.p[1]    = '0;
      f.p[2]    = '0;
      return f;
   endfunction

   // Later joints: alpha of zero, link offset along x
   function automatic frame_type link_frame(trig_type c, trig_type s, pos_type px, pos_type py);
      frame_type f;
      f.r[0][0] = rot_type'(c);
      f.r[0][1] = -rot_type'(s);
      f.r[0][2] = '0;
      f.r[1][0] = rot_type'(s);
      f.r[1][1] = rot_type'(c);
      f.r[1][2] = '0;
      f.r[2][0] = '0;
      f.r[2][1] = '0;
      f.r[2][2] = ROT_ONE;
      f.p[0]    = px;
      f.p[1]    = py;
      f.p[2]    = '0;
      return f;
   endfunction

   // Multiply step of a composition: every partial product
   function automatic cprod_type frame_products(frame_type a, frame_type t);
      cprod_type cp;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               cp.rr[i][j][k] = a.r[i][k] * t.r[k][j];
            end
         end
         for (int k = 0; k < 3; k++) begin
            cp.rp[i][k] = a.r[i][k] * t.p[k];
         end
         cp.ap[i] = a.p[i];
      end
      return cp;
   endfunction

   // Translation row of a composition from its partial products
   function automatic pos_type pos_sum(cprod_type cp, int i);
      sum_type s;
      s = sum_type'(cp.rp[i][0]) + sum_type'(cp.rp[i][1]) + sum_type'(cp.rp[i][2]);
      return pos_type'(round15(s)) + cp.ap[i];
   endfunction

   // Accumulate step of a composition
   function automatic frame_type frame_sum(cprod_type cp);
      frame_type f;
      sum_type   s;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s = sum_type'(cp.rr[i][j][0]) + sum_type'(cp.rr[i][j][1])
                + sum_type'(cp.rr[i][j][2]);
            f.r[i][j] = rot_type'(round15(s));
         end
         f.p[i] = pos_sum(cp, i);
      end
      return f;
   endfunction

   // Clamp a translation to the output range
   function automatic coord_type saturate(pos_type v);
      if (v > pos_type'(COORD_MAX)) begin
         return COORD_MAX;
      end else if (v < pos_type'(COORD_MIN)) begin
         return COORD_MIN;
      end
      return coord_type'(v);
   endfunction

endpackage

>>> rtl/core/dhfk_channel_if.sv
// ----------------------------------------------------------------------------
// DH chain forward kinematics: channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface dhfk_req_if #(parameter int ANGLE_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] coxa_angle;
   logic signed [ANGLE_BITS-1:0] thigh_angle;
   logic signed [ANGLE_BITS-1:0] knee_angle;
   logic signed [ANGLE_BITS-1:0] tarsus_angle;

   modport source (output valid, coxa_angle, thigh_angle, knee_angle,
                   tarsus_angle, input ready);
   modport sink   (input valid, coxa_angle, thigh_angle, knee_angle,
                   tarsus_angle, output ready);
endinterface

interface dhfk_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [18:0] foot_x;
   logic signed [18:0] foot_y;
   logic signed [18:0] foot_z;

   modport source (output valid, foot_x, foot_y, foot_z, input ready);
   modport sink   (input valid, foot_x, foot_y, foot_z, output ready);
endinterface

>>> rtl/core/dhfk_trig_front.sv
// ----------------------------------------------------------------------------
// DH chain forward kinematics: trig front end
// Eight pipelined sine lanes (sine and cosine of four joints), one pose a cycle unless the queue is full.
// ----------------------------------------------------------------------------
module dhfk_trig_front #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [ANGLE_BITS-1:0]         in_angle [4],
   output logic                          in_ready,
   output logic                          out_valid,
   output dhfk_pkg::trig_item_type       out_trig,
   input  logic                          out_ready
);
   import dhfk_pkg::*;

   localparam int PAD = 32 - ANGLE_BITS;
   localparam logic [31:0] QUARTER = 32'h4000_0000;

   logic               en;
   logic               fv_ff [7];
   logic [30:0]        x0_in [8];
   logic               ng0_in [8];
   logic [30:0]        x_ff  [6][8];
   logic               ng_ff [7][8];
   logic [30:0]        sq_ff [4][8];
   logic signed [32:0] t_ff  [4][8];
   logic signed [34:0] q_ff  [8];
   logic [30:0]        sq_in [8];
   logic signed [32:0] t_in  [4][8];
   logic signed [34:0] q_in  [8];

   // Fold a circle angle into the first quadrant, Q1.30
   function automatic logic [30:0] fold(logic [31:0] c);
      logic [30:0] f;
      f = {1'b0, c[29:0]};
      return c[30] ? (31'h4000_0000 - f) : f;
   endfunction

   // Round to Q1.15, clamp, apply the half-turn sign
   function automatic trig_type finish(logic signed [34:0] q, logic ng);
      logic signed [34:0] r;
      trig_type           m;
      r = (q + 35'sd16384) >>> 15;
      if (r < 0) begin
         m = '0;
      end else if (r > 35'sd32768) begin
         m = TRIG_ONE;
      end else begin
         m = trig_type'(r);
      end
      return ng ? -m : m;
   endfunction

   // Stall the whole front while the queue is full
   assign en       = out_ready;
   assign in_ready = en;

   // Place angles on the circle and fold; lanes 0-3 sine, 4-7 cosine
   always_comb begin
      logic [31:0] cs;
      logic [31:0] cc;
      for (int j = 0; j < 4; j++) begin
         cs = {in_angle[j], {PAD{1'b0}}};
         cc = cs + QUARTER;
         x0_in[j]    = fold(cs);
         ng0_in[j]   = cs[31];
         x0_in[j+4]  = fold(cc);
         ng0_in[j+4] = cc[31];
      end
   end

   // Square, Horner steps and last product, one multiply per stage
   always_comb begin
      logic [61:0]        xx;
      logic signed [32:0] tp;
      logic signed [64:0] pr;
      for (int l = 0; l < 8; l++) begin
         xx       = x_ff[0][l] * x_ff[0][l];
         sq_in[l] = xx[60:30];
         tp       = SIN_POLY[4];
         for (int h = 0; h < 4; h++) begin
            pr         = tp * $signed({1'b0, sq_ff[h][l]});
            t_in[h][l] = 33'((pr >>> 30) + 65'(SIN_POLY[3-h]));
            tp         = t_ff[h][l];
         end
         pr      = t_ff[3][l] * $signed({1'b0, x_ff[5][l]});
         q_in[l] = 35'(pr >>> 30);
      end
   end

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 7; s++) begin
            fv_ff[s] <= 1'b0;
         end
      end else if (en) begin
         fv_ff[0] <= in_valid;
         for (int s = 1; s < 7; s++) begin
            fv_ff[s] <= fv_ff[s-1];
         end
      end
   end

   // Advance the lane payloads
   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 8; l++) begin
            x_ff[0][l]  <= x0_in[l];
            ng_ff[0][l] <= ng0_in[l];
            for (int s = 1; s < 6; s++) begin
               x_ff[s][l] <= x_ff[s-1][l];
            end
            for (int s = 1; s < 7; s++) begin
               ng_ff[s][l] <= ng_ff[s-1][l];
            end
            sq_ff[0][l] <= sq_in[l];
            for (int h = 1; h < 4; h++) begin
               sq_ff[h][l] <= sq_ff[h-1][l];
            end
            for (int h = 0; h < 4; h++) begin
               t_ff[h][l] <= t_in[h][l];
            end
            q_ff[l] <= q_in[l];
         end
      end
   end

   // Finish the lanes into one trig item
   assign out_valid = fv_ff[6];
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         out_trig.sn[j] = finish(q_ff[j], ng_ff[6][j]);
         out_trig.cs[j] = finish(q_ff[j+4], ng_ff[6][j+4]);
      end
   end

endmodule

>>> rtl/core/dhfk_queue.sv
// ----------------------------------------------------------------------------
// DH chain forward kinematics: trig queue
// Short FIFO that decouples the trig front end from the matrix back end.
// ----------------------------------------------------------------------------
module dhfk_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  dhfk_pkg::trig_item_type push_data,
   output logic                    push_ready,
   output logic                    pop_valid,
   output dhfk_pkg::trig_item_type pop_data,
   input  logic                    pop_ready
);
   import dhfk_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   trig_item_type  mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ff;
   logic [PW-1:0]  rd_ff;
   logic [PW:0]    cnt_ff;
   logic [PW:0]    cnt_in;
   logic           push;
   logic           pop;

   assign push_ready = (cnt_ff != (PW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ff];

   // Track occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/dhfk_chain_back.sv
// ----------------------------------------------------------------------------
// DH chain forward kinematics: matrix back end
// Builds joint frames and composes them in alternating multiply/sum stages.
// ----------------------------------------------------------------------------
module dhfk_chain_back #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  dhfk_pkg::trig_item_type  in_trig,
   output logic                     in_ready,
   input  logic [LENGTH_BITS-1:0]   link_len [3],
   output logic                     out_valid,
   output dhfk_pkg::coord_type      out_x,
   output dhfk_pkg::coord_type      out_y,
   output dhfk_pkg::coord_type      out_z,
   input  logic                     out_ready
);
   import dhfk_pkg::*;

   logic          en;
   logic          bv_ff [8];
   trig_item_type tr0_ff;
   prod_type      lp0_ff [3][2];
   frame_type     acc1_ff;
   frame_type     tf1_ff [3];
   cprod_type     cp2_ff;
   frame_type     tf2_ff [2];
   frame_type     acc3_ff;
   frame_type     tf3_ff [2];
   cprod_type     cp4_ff;
   frame_type     tf4_ff;
   frame_type     acc5_ff;
   frame_type     tf5_ff;
   cprod_type     cp6_ff;
   coord_type     x_ff;
   coord_type     y_ff;
   coord_type     z_ff;
   pos_type       lp_rnd [3][2];

   // Stall the whole back end only while the result is held
   assign en        = !bv_ff[7] || out_ready;
   assign in_ready  = en;
   assign out_valid = bv_ff[7];
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

   // Round the link offset products
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 2; k++) begin
            lp_rnd[j][k] = pos_type'(round15(sum_type'(lp0_ff[j][k])));
         end
      end
   end

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 8; s++) begin
            bv_ff[s] <= 1'b0;
         end
      end else if (en) begin
         bv_ff[0] <= in_valid;
         for (int s = 1; s < 8; s++) begin
            bv_ff[s] <= bv_ff[s-1];
         end
      end
   end

   // Stage payloads: link products, frames, then three compositions
   always_ff @(posedge clock) begin
      if (en) begin
         tr0_ff <= in_trig;
         for (int j = 0; j < 3; j++) begin
            lp0_ff[j][0] <= $signed({1'b0, link_len[j]}) * in_trig.cs[j+1];
            lp0_ff[j][1] <= $signed({1'b0, link_len[j]}) * in_trig.sn[j+1];
         end
         acc1_ff <= base_frame(tr0_ff.cs[0], tr0_ff.sn[0]);
         for (int j = 0; j < 3; j++) begin
            tf1_ff[j] <= link_frame(tr0_ff.cs[j+1], tr0_ff.sn[j+1],
                                    lp_rnd[j][0], lp_rnd[j][1]);
         end
         cp2_ff    <= frame_products(acc1_ff, tf1_ff[0]);
         tf2_ff[0] <= tf1_ff[1];
         tf2_ff[1] <= tf1_ff[2];
         acc3_ff   <= frame_sum(cp2_ff);
         tf3_ff    <= tf2_ff;
         cp4_ff    <= frame_products(acc3_ff, tf3_ff[0]);
         tf4_ff    <= tf3_ff[1];
         acc5_ff   <= frame_sum(cp4_ff);
         tf5_ff    <= tf4_ff;
         cp6_ff    <= frame_products(acc5_ff, tf5_ff);
         x_ff      <= saturate(pos_sum(cp6_ff, 0));
         y_ff      <= saturate(pos_sum(cp6_ff, 1));
         z_ff      <= saturate(pos_sum(cp6_ff, 2));
      end
   end

endmodule

>>> rtl/core/dh_chain_forward_kinematics.sv
// ----------------------------------------------------------------------------
// DH chain forward kinematics: top level
// Four-joint leg pose to foot position through a DH transform chain.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  req_if   | in        | coxa, thigh, knee, tarsus angles
//  rsp_if   | out       | foot_x, foot_y, foot_z (Q4.14, saturated)
//  csr_*    | in        | femur, tibia, foot link lengths
//
//  One pose accepted per cycle while nothing stalls; a pose passes the sine
//  lanes, then the queue, then the matrix stages.
//  A four-entry queue lets the sine lanes run while the result is stalled.
//  Synchronous reset clears all valid state; link lengths reset to zero.
// ----------------------------------------------------------------------------
module dh_chain_forward_kinematics #(
   parameter int ANGLE_BITS  = 16,
   parameter int LENGTH_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   dhfk_req_if.sink               req_if,
   dhfk_rsp_if.source             rsp_if,
   input  logic                   csr_write_en,
   input  logic [1:0]             csr_index,
   input  logic [LENGTH_BITS-1:0] csr_write_data
);
   import dhfk_pkg::*;

   logic [ANGLE_BITS-1:0]  angle [4];
   logic [LENGTH_BITS-1:0] len_ff [3];
   logic                   fr_valid;
   logic                   fr_ready;
   trig_item_type          fr_trig;
   logic                   q_valid;
   logic                   q_ready;
   trig_item_type          q_trig;

   // Write the link length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 3; j++) begin
            len_ff[j] <= '0;
         end
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FEMUR_LENGTH: len_ff[0] <= csr_write_data;
            CSR_TIBIA_LENGTH: len_ff[1] <= csr_write_data;
            CSR_FOOT_LENGTH:  len_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign angle[0] = req_if.coxa_angle;
   assign angle[1] = req_if.thigh_angle;
   assign angle[2] = req_if.knee_angle;
   assign angle[3] = req_if.tarsus_angle;

   dhfk_trig_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_angle  (angle),
      .in_ready  (req_if.ready),
      .out_valid (fr_valid),
      .out_trig  (fr_trig),
      .out_ready (fr_ready)
   );

   dhfk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_data  (fr_trig),
      .push_ready (fr_ready),
      .pop_valid  (q_valid),
      .pop_data   (q_trig),
      .pop_ready  (q_ready)
   );

   dhfk_chain_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_trig   (q_trig),
      .in_ready  (q_ready),
      .link_len  (len_ff),
      .out_valid (rsp_if.valid),
      .out_x     (rsp_if.foot_x),
      .out_y     (rsp_if.foot_y),
      .out_z     (rsp_if.foot_z),
      .out_ready (rsp_if.ready)
   );

endmodule

>>> rtl/core/dhfk_checker.sv
// ----------------------------------------------------------------------------
// DH chain forward kinematics: port checker
// Watches the top level's channels for hold rules and responses without a request.
// ----------------------------------------------------------------------------
`include "dh_chain_forward_kinematics_defines.svh"

module dhfk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [18:0] foot_x,
   input logic [18:0] foot_y,
   input logic [18:0] foot_z
);
   logic [5:0]  pend_ff;
   logic        req_acc;
   logic        rsp_acc;
   logic        rsp_stall;
   logic [56:0] foot_all;

   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign foot_all  = {foot_x, foot_y, foot_z};

   // Count requests still owed a response
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (req_acc && !rsp_acc) begin
         pend_ff <= pend_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         pend_ff <= pend_ff - 1'b1;
      end
   end

   `DHFK_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "stalled response dropped")
   `DHFK_ASSERT(a_rsp_stable, clock, reset, rsp_stall |=> $stable(foot_all), "response changed")
   `DHFK_ASSERT(a_no_orphan, clock, reset, rsp_valid |-> pend_ff != '0, "response without request")
   `DHFK_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind dh_chain_forward_kinematics dhfk_checker u_dhfk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .foot_x    (rsp_if.foot_x),
   .foot_y    (rsp_if.foot_y),
   .foot_z    (rsp_if.foot_z)
);

>>> tb/tb_dh_chain_forward_kinematics.sv
// ----------------------------------------------------------------------------
// DH chain forward kinematics: testbench
// Drives joint-angle requests with random gaps, predicts each foot position
// with a fixed-point DH chain model, and checks responses in order under
// random response back-pressure across several link-length settings.
// ----------------------------------------------------------------------------
module tb_dh_chain_forward_kinematics;
   import dhfk_pkg::*;

   typedef struct {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] knee;
      logic signed [15:0] ankle;
   } pose_type;

   typedef struct {
      logic [18:0] x;
      logic [18:0] y;
      logic [18:0] z;
   } foot_type;

   typedef struct {
      longint r[3][3];
      longint p[3];
   } tf_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [1:0] csr_index;
   logic [15:0] csr_write_data;

   dhfk_req_if #(.ANGLE_BITS(16)) req_if ();
   dhfk_rsp_if rsp_if ();

   dh_chain_forward_kinematics DUT (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   pose_type pending_poses[$];
   foot_type expected_feet[$];
   longint   link_len[3];
   int       error_count = 0;
   int       cycle_count = 0;
   bit       calm_req = 0;
   bit       calm_rsp = 0;
   bit       req_fire = 0;
   localparam int CYCLE_LIMIT = 400000;

   // Clock: period 10
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint fshr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint rshr(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   // Odd polynomial for a quarter turn, Q2.30
   function automatic longint quarter_sin(longint x);
      longint coef[5];
      longint x2;
      longint t;
      coef = '{1686629713, -693598668, 85569306, -5026995, 172272};
      x2 = (x * x) >>> 30;
      t = coef[4];
      for (int i = 3; i >= 0; i--) t = coef[i] + fshr(t * x2, 30);
      return fshr(t * x, 30);
   endfunction

   function automatic longint sin_q15(logic [31:0] a);
      logic [1:0] quad;
      longint f;
      longint r;
      quad = a[31:30];
      f = longint'(a[29:0]);
      if (quad[0]) f = (longint'(1) << 30) - f;
      r = rshr(quarter_sin(f), 15);
      if (r < 0) r = 0;
      if (r > 32768) r = 32768;
      return quad[1] ? -r : r;
   endfunction

   function automatic tf_type joint_tf(logic [15:0] ang, longint ca, longint sa, longint len);
      tf_type t;
      logic [31:0] a;
      longint ct;
      longint st;
      a = {ang, 16'h0};
      ct = sin_q15(a + 32'h4000_0000);
      st = sin_q15(a);
      t.r[0][0] = ct;
      t.r[0][1] = rshr(-(st * ca), 15);
      t.r[0][2] = rshr(st * sa, 15);
      t.r[1][0] = st;
      t.r[1][1] = rshr(ct * ca, 15);
      t.r[1][2] = rshr(-(ct * sa), 15);
      t.r[2][0] = 0;
      t.r[2][1] = sa;
      t.r[2][2] = ca;
      t.p[0] = rshr(len * ct, 15);
      t.p[1] = rshr(len * st, 15);
      t.p[2] = 0;
      return t;
   endfunction

   function automatic tf_type chain(tf_type a, tf_type t);
      tf_type n;
      longint s;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s = 0;
            for (int k = 0; k < 3; k++) s += a.r[i][k] * t.r[k][j];
            n.r[i][j] = rshr(s, 15);
         end
         s = 0;
         for (int k = 0; k < 3; k++) s += a.r[i][k] * t.p[k];
         n.p[i] = rshr(s, 15) + a.p[i];
      end
      return n;
   endfunction

   function automatic logic [18:0] clamp_coord(longint v);
      if (v > 262143) v = 262143;
      if (v < -262144) v = -262144;
      return v[18:0];
   endfunction

   function automatic foot_type predict_foot(pose_type p);
      tf_type acc;
      foot_type f;
      acc = joint_tf(p.roll, 0, 32768, 0);
      acc = chain(acc, joint_tf(p.pitch, 32768, 0, link_len[0]));
      acc = chain(acc, joint_tf(p.knee, 32768, 0, link_len[1]));
      acc = chain(acc, joint_tf(p.ankle, 32768, 0, link_len[2]));
      f.x = clamp_coord(acc.p[0]);
      f.y = clamp_coord(acc.p[1]);
      f.z = clamp_coord(acc.p[2]);
      return f;
   endfunction

   // Driver: drop the accepted request, hold a waiting one, else advance
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_fire) begin
            void'(pending_poses.pop_front());
         end
         if (req_if.valid && !req_fire) begin
            req_if.valid <= 1'b1;
         end else if (pending_poses.size() > 0 &&
                      (calm_req || $urandom_range(99) >= 12)) begin
            req_if.coxa_angle   <= pending_poses[0].roll;
            req_if.thigh_angle  <= pending_poses[0].pitch;
            req_if.knee_angle   <= pending_poses[0].knee;
            req_if.tarsus_angle <= pending_poses[0].ankle;
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= reset ? 1'b0 : (calm_rsp || $urandom_range(99) >= 12);
   end

   // Predict on accepted request, check on accepted response
   always @(posedge clock) begin
      foot_type exp_foot;
      cycle_count <= cycle_count + 1;
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         pose_type p;
         p.roll = req_if.coxa_angle;
         p.pitch = req_if.thigh_angle;
         p.knee = req_if.knee_angle;
         p.ankle = req_if.tarsus_angle;
         expected_feet.push_back(predict_foot(p));
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_feet.size() == 0) begin
            $error("unexpected response x=%0d", rsp_if.foot_x);
            error_count++;
         end else begin
            exp_foot = expected_feet.pop_front();
            if (rsp_if.foot_x !== exp_foot.x) begin
               $error("foot_x expected %h actual %h", exp_foot.x, rsp_if.foot_x);
               error_count++;
            end
            if (rsp_if.foot_y !== exp_foot.y) begin
               $error("foot_y expected %h actual %h", exp_foot.y, rsp_if.foot_y);
               error_count++;
            end
            if (rsp_if.foot_z !== exp_foot.z) begin
               $error("foot_z expected %h actual %h", exp_foot.z, rsp_if.foot_z);
               error_count++;
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_link(csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx != CSR_UNUSED) link_len[idx] = value;
   endtask

   task automatic queue_pose(logic [15:0] r, logic [15:0] p, logic [15:0] k,
                             logic [15:0] a);
      pose_type ps;
      ps.roll = r;
      ps.pitch = p;
      ps.knee = k;
      ps.ankle = a;
      pending_poses.push_back(ps);
   endtask

   // Hold until all requests are out and every response has arrived
   task automatic drain();
      wait (pending_poses.size() == 0 && !req_if.valid);
      wait (expected_feet.size() == 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic random_poses(int n);
      for (int i = 0; i < n; i++) begin
         queue_pose(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      logic [15:0] edge_angles[6];
      edge_angles = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'hFFFF};
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_FEMUR_LENGTH;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.coxa_angle = '0;
      req_if.thigh_angle = '0;
      req_if.knee_angle = '0;
      req_if.tarsus_angle = '0;
      rsp_if.ready = 1'b0;
      link_len = '{0, 0, 0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: lengths at reset, then extremes and the minus-pi code
      queue_pose(16'h1234, 16'h4000, 16'h8000, 16'h7FFF);
      drain();
      write_link(CSR_FEMUR_LENGTH, 16'hFFFF);
      write_link(CSR_TIBIA_LENGTH, 16'hFFFF);
      write_link(CSR_FOOT_LENGTH, 16'hFFFF);
      write_link(CSR_UNUSED, 16'h1111);
      for (int i = 0; i < 6; i++) begin
         queue_pose(edge_angles[i], edge_angles[(i + 1) % 6], edge_angles[(i + 2) % 6],
                    edge_angles[(i + 3) % 6]);
      end
      queue_pose(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      queue_pose(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      queue_pose(16'h4000, 16'h0000, 16'h0000, 16'h0000);
      drain();

      // Random phases over several link settings
      calm_req = 1;
      calm_rsp = 1;
      random_poses(200);
      drain();
      calm_req = 0;
      calm_rsp = 0;
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin
               write_link(CSR_FEMUR_LENGTH, 16'h0000);
               write_link(CSR_TIBIA_LENGTH, 16'h0001);
               write_link(CSR_FOOT_LENGTH, 16'hFFFF);
            end
            1: begin
               write_link(CSR_FEMUR_LENGTH, 16'h4000);
               write_link(CSR_TIBIA_LENGTH, 16'h4000);
               write_link(CSR_FOOT_LENGTH, 16'h1000);
            end
            default: begin
               write_link(CSR_FEMUR_LENGTH, 16'($urandom));
               write_link(CSR_TIBIA_LENGTH, 16'($urandom));
               write_link(CSR_FOOT_LENGTH, 16'($urandom));
            end
         endcase
         random_poses(250);
         drain();
      end

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/dhfk_pkg.sv
rtl/core/dhfk_channel_if.sv
rtl/core/dhfk_trig_front.sv
rtl/core/dhfk_queue.sv
rtl/core/dhfk_chain_back.sv
rtl/core/dh_chain_forward_kinematics.sv
rtl/core/dhfk_checker.sv
tb/tb_dh_chain_forward_kinematics.sv
